@@ rtl/bwag_pkg.sv @@
// band window average and gain: shared types and constants
// used by bwag_lane, bwag_merge and band_window_average_and_gain_top
`default_nettype none

package bwag_pkg;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_GAIN   = 1'b0,
        CFG_OFFSET = 1'b1
    } t_cfg_idx;

    // saturation limit of the conditioned level
    localparam int LEVEL_MAX = 255;

    // per-item strobes that move a reading through every lane
    typedef struct packed {
        logic wr;    // reading accepted: write window, fetch oldest entry
        logic acc;   // update the running window sum
    } t_lane_ctl;

endpackage

`default_nettype wire

@@ rtl/bwag_lane.sv @@
// one band lane: window memory, running sum, mean by reciprocal and gain/offset
// depends on bwag_pkg
`default_nettype none

module bwag_lane #(
    parameter int WINDOW = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire bwag_pkg::t_lane_ctl         i_ctl,
    input  wire logic [7:0]                  i_level,
    input  wire logic [$clog2(WINDOW)-1:0]   i_addr,
    input  wire logic                        i_filled,
    input  wire logic [15:0]                 i_gain,
    input  wire logic signed [8:0]           i_offset,
    output logic [7:0]                       o_avg,
    output logic [7:0]                       o_scaled
);
    import bwag_pkg::*;

    localparam int SW = $clog2(255 * WINDOW + 1);
    // reciprocal of the window length, scaled by 2^SW
    localparam int RECIP = (1 << SW) / WINDOW;

    logic [7:0]          r_mem [WINDOW];
    logic [7:0]          r_old;
    logic [7:0]          r_lvl;
    logic                r_fill;
    logic [SW-1:0]       r_sum;
    logic [23:0]         r_prod;
    logic [SW-1:0]       r_qe;
    logic [7:0]          r_cond;
    logic [7:0]          r_avg;

    logic [SW-1:0]       n_sum;
    logic [2*SW-1:0]     qe_full;
    logic [SW-1:0]       rem;
    logic [7:0]          n_cond;
    logic [15:0]         prod16;
    logic signed [17:0]  off_sum;
    logic [17:0]         pick;

    // window memory: read the oldest entry while writing the new one
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_addr] <= i_level;
            r_old         <= r_mem[i_addr];
            r_lvl         <= i_level;
            r_fill        <= i_filled;
        end
    end

    // running sum: add the new reading, drop the one it replaced once the window has filled
    always_comb begin
        n_sum = r_sum + SW'(r_lvl) - (r_fill ? SW'(r_old) : SW'(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctl.acc) begin
            r_sum <= n_sum;
        end
    end

    // gain product
    always_ff @(posedge i_clk) begin
        r_prod <= r_lvl * i_gain;
    end

    // conditioned level: offset kept only if the sum is non-negative, then saturate
    always_comb begin
        prod16  = r_prod[23:8];
        off_sum = $signed({2'b00, prod16}) + 18'(i_offset);
        if (off_sum >= 0) begin
            pick = off_sum;
        end else begin
            pick = {2'b00, prod16};
        end
        if (pick > 18'(LEVEL_MAX)) begin
            n_cond = 8'(LEVEL_MAX);
        end else begin
            n_cond = pick[7:0];
        end
    end

    // mean estimate by reciprocal, low by at most one
    always_comb begin
        qe_full = r_sum * (2*SW)'(RECIP);
    end

    always_ff @(posedge i_clk) begin
        r_qe   <= qe_full[2*SW-1:SW];
        r_cond <= n_cond;
    end

    // one correction step on the mean
    always_comb begin
        rem = r_sum - SW'(r_qe * SW'(WINDOW));
    end

    always_ff @(posedge i_clk) begin
        if (rem >= SW'(WINDOW)) begin
            r_avg <= 8'(r_qe + SW'(1));
        end else begin
            r_avg <= r_qe[7:0];
        end
    end

    assign o_avg    = r_avg;
    assign o_scaled = r_cond;

endmodule

`default_nettype wire

@@ rtl/bwag_merge.sv @@
// merging stage: takes the lane results of one reading, sends them band by band
// depends on bwag_pkg
`default_nettype none

module bwag_merge #(
    parameter int BANDS = 7
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_pend,
    input  wire logic [BANDS-1:0][7:0]  i_avg,
    input  wire logic [BANDS-1:0][7:0]  i_scaled,
    output logic                        o_take,
    output logic                        o_tvalid,
    input  wire logic                   i_tready,
    output logic [23:0]                 o_tdata,
    output logic                        o_tlast
);
    import bwag_pkg::*;

    localparam int IW = (BANDS > 1) ? $clog2(BANDS) : 1;

    logic [7:0]     r_avg [BANDS];
    logic [7:0]     r_scl [BANDS];
    logic [IW-1:0]  r_cnt;
    logic           r_busy;

    logic           xfer;
    logic           last;
    logic           load;

    // transfer bookkeeping
    always_comb begin
        xfer = r_busy && i_tready;
        last = (r_cnt == IW'(BANDS - 1));
        load = i_pend && (!r_busy || (xfer && last));
    end

    // result bank and band counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (xfer) begin
            if (last) begin
                r_busy <= 1'b0;
                r_cnt  <= '0;
            end else begin
                r_cnt <= r_cnt + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int b = 0; b < BANDS; b++) begin
                r_avg[b] <= i_avg[b];
                r_scl[b] <= i_scaled[b];
            end
        end
    end

    assign o_take   = load;
    assign o_tvalid = r_busy;
    assign o_tlast  = last;
    assign o_tdata  = {5'b0, r_scl[r_cnt], r_avg[r_cnt], 3'(r_cnt)};

endmodule

`default_nettype wire

@@ rtl/band_window_average_and_gain_top.sv @@
// band window average and gain, top level
// depends on bwag_pkg, bwag_lane and bwag_merge
//
// One input transfer carries a reading of seven 8-bit band levels (band 0 in
// the lowest byte of s_axis_tdata). Each band runs in its own lane, which keeps
// the last WINDOW readings of that band and a running sum of them. For every
// used band, in order, one output transfer carries the band number, the
// truncated window mean and the level times the Q8.8 gain with the signed
// offset (skipped if it would go negative), saturated at 255; tlast marks the
// last band.
// Each lane registers the reading, then the window sum and gain product, then
// the mean estimate and conditioned level, then the corrected mean. A new
// reading enters once the last is in the single output channel, which sends
// one band per cycle while the receiver is ready and the next is in the lanes.
// Reset clears the window sums, write cursor and handshake state, and loads
// gain 256 and offset 0; window memory needs no clearing since entries not
// yet written are counted as zero until the cursor first wraps.
// When the receiver stalls, results hold; one finished reading waits behind
// the one being sent, then s_axis_tready drops.
// Configuration must be written only while idle through the write port; the block itself does not enforce this.
`default_nettype none

module band_window_average_and_gain_top #(
    parameter int WINDOW = 16,
    parameter int BANDS  = 7
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // config write port
    input  wire logic                     i_cfg_wr_en,
    input  wire bwag_pkg::t_cfg_idx       i_cfg_index,
    input  wire logic [15:0]              i_cfg_wdata,
    // input stream
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [55:0]              s_axis_tdata,  // level_band0 .. level_band6
    // output stream
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic [23:0]                   m_axis_tdata,  // band_number, window_average,
                                                         // scaled_level, zero pad
    output logic                          m_axis_tlast   // last_band
);
    import bwag_pkg::*;

    localparam int AW = $clog2(WINDOW);

    logic [15:0]             r_gain;
    logic signed [8:0]       r_offset;
    logic [AW-1:0]           r_cur;
    logic                    r_filled;
    logic [3:0]              r_pipe;
    logic                    r_pend;

    logic                    accept;
    logic                    take;
    t_lane_ctl               ctl;
    logic [BANDS-1:0][7:0]   lane_avg;
    logic [BANDS-1:0][7:0]   lane_scl;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= 16'd256;
            r_offset <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_GAIN:   r_gain   <= i_cfg_wdata;
                CFG_OFFSET: r_offset <= i_cfg_wdata[8:0];
                default:    ;
            endcase
        end
    end

    // input handshake: one reading in the lanes at a time, none during reset
    assign s_axis_tready = i_rst_n && (r_pipe == 4'b0) && !r_pend;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        ctl.wr  = accept;
        ctl.acc = r_pipe[0];
    end

    // shared write cursor and first-wrap flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur    <= '0;
            r_filled <= 1'b0;
        end else if (accept) begin
            if (r_cur == AW'(WINDOW - 1)) begin
                r_cur    <= '0;
                r_filled <= 1'b1;
            end else begin
                r_cur <= r_cur + AW'(1);
            end
        end
    end

    // lane pipeline tracking and finished-reading flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe <= '0;
            r_pend <= 1'b0;
        end else begin
            r_pipe <= {r_pipe[2:0], accept};
            if (r_pipe[3]) begin
                r_pend <= 1'b1;
            end else if (take) begin
                r_pend <= 1'b0;
            end
        end
    end

    // one lane per band
    for (genvar b = 0; b < BANDS; b++) begin : g_lane
        bwag_lane #(
            .WINDOW (WINDOW)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (ctl),
            .i_level  (s_axis_tdata[8*b +: 8]),
            .i_addr   (r_cur),
            .i_filled (r_filled),
            .i_gain   (r_gain),
            .i_offset (r_offset),
            .o_avg    (lane_avg[b]),
            .o_scaled (lane_scl[b])
        );
    end

    // serialize lane results onto the output stream
    bwag_merge #(
        .BANDS (BANDS)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pend   (r_pend),
        .i_avg    (lane_avg),
        .i_scaled (lane_scl),
        .o_take   (take),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

@@ bench/tb_band_window_average_and_gain_top.sv @@
// testbench for band_window_average_and_gain_top: drives band readings, predicts
// the seven band results of each reading and checks every output transfer
// depends on bwag_pkg and the band_window_average_and_gain_top rtl
`timescale 1ns / 1ps

module tb_band_window_average_and_gain_top;

    import bwag_pkg::*;

    localparam int WINDOW       = 16;
    localparam int BANDS        = 7;
    localparam int CLK_HALF     = 6;
    localparam int DRAIN_CYCLES = 12;
    localparam int IDLE_LIMIT   = 5000;

    // one expected band result
    typedef struct packed {
        logic [2:0] band_number;
        logic [7:0] window_average;
        logic [7:0] scaled_level;
        logic       last_band;
    } t_band_result;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    t_cfg_idx    i_cfg_index   = CFG_GAIN;
    logic [15:0] i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata  = '0;  // level_band0 .. level_band6
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // band_number, window_average, scaled_level, zero pad
    logic        m_axis_tlast;        // last_band

    // predictor state
    logic [7:0]   level_window [BANDS][WINDOW];
    int           window_slot;
    logic [15:0]  gain_setting;
    int           offset_setting;
    t_band_result pending_results [$];
    t_band_result oldest_result;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int idle_cycles    = 0;

    band_window_average_and_gain_top #(
        .WINDOW(WINDOW),
        .BANDS (BANDS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // store a reading in the windows and queue the band results it causes
    task automatic predict_band_results(input logic [55:0] levels);
        logic [7:0] lv;
        int         sum;
        int         prod;
        int         with_offset;
        t_band_result res;
        for (int b = 0; b < BANDS; b++) begin
            level_window[b][window_slot] = levels[8*b +: 8];
        end
        for (int b = 0; b < BANDS; b++) begin
            lv  = levels[8*b +: 8];
            sum = 0;
            for (int k = 0; k < WINDOW; k++) sum += level_window[b][k];
            prod        = (int'(lv) * int'(gain_setting)) >>> 8;
            with_offset = prod + offset_setting;
            // offset is skipped when it would drive the level negative
            if (with_offset >= 0) prod = with_offset;
            if (prod > LEVEL_MAX) prod = LEVEL_MAX;
            res.band_number    = 3'(b);
            res.window_average = 8'(sum / WINDOW);
            res.scaled_level   = 8'(prod);
            res.last_band      = (b == BANDS - 1);
            pending_results.push_back(res);
        end
        window_slot = (window_slot + 1) % WINDOW;
    endtask

    // result checker and watchdog activity counter
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected: tdata %h tlast %b",
                       m_axis_tdata, m_axis_tlast);
                error_count++;
            end else begin
                oldest_result = pending_results.pop_front();
                if (m_axis_tdata[2:0] !== oldest_result.band_number) begin
                    $error("band_number: expected %0d, got %0d",
                           oldest_result.band_number, m_axis_tdata[2:0]);
                    error_count++;
                end
                if (m_axis_tdata[10:3] !== oldest_result.window_average) begin
                    $error("window_average: expected %0d, got %0d",
                           oldest_result.window_average, m_axis_tdata[10:3]);
                    error_count++;
                end
                if (m_axis_tdata[18:11] !== oldest_result.scaled_level) begin
                    $error("scaled_level: expected %0d, got %0d",
                           oldest_result.scaled_level, m_axis_tdata[18:11]);
                    error_count++;
                end
                if (m_axis_tlast !== oldest_result.last_band) begin
                    $error("last_band: expected %0d, got %0d",
                           oldest_result.last_band, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    // one reading transfer, with random idle cycles ahead of it
    task automatic send_reading(input logic [55:0] levels);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= levels;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_band_results(levels);
    endtask

    // stop sending and wait until every expected result has arrived
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // write both registers back to back, only while idle
    task automatic apply_settings(input logic [15:0] gain, input int offset);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_GAIN;
        i_cfg_wdata <= gain;
        @(posedge i_clk);
        i_cfg_index <= CFG_OFFSET;
        i_cfg_wdata <= 16'(offset);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        gain_setting   = gain;
        offset_setting = offset;
    endtask

    // band levels biased toward the extremes and toward small values
    function automatic logic [55:0] random_reading();
        logic [55:0] levels;
        for (int b = 0; b < BANDS; b++) begin
            case ($urandom_range(3))
                0:       levels[8*b +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
                1:       levels[8*b +: 8] = 8'($urandom_range(15));
                default: levels[8*b +: 8] = 8'($urandom);
            endcase
        end
        return levels;
    endfunction

    // reset defaults and a window still partly filled with zeros
    task automatic test_early_window();
        logic [55:0] ramp;
        for (int b = 0; b < BANDS; b++) ramp[8*b +: 8] = 8'(b * 37);
        send_reading({7{8'h00}});
        send_reading({7{8'hFF}});
        send_reading(ramp);
        send_reading({8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55});
        drain_results();
    endtask

    // fill the window and wrap the write cursor
    task automatic test_window_wrap();
        logic [55:0] levels;
        for (int k = 0; k <= WINDOW; k++) begin
            for (int b = 0; b < BANDS; b++) levels[8*b +: 8] = 8'(255 - k * 13 + b * 29);
            send_reading(levels);
        end
        drain_results();
    endtask

    // gain and offset corners: saturation, negative sum, offset of -256
    task automatic test_gain_offset_extremes();
        logic [15:0] gains   [5] = '{16'hFFFF, 16'h0000, 16'h0100, 16'h0080, 16'h0001};
        int          offsets [5] = '{255, -256, -255, 255, -1};
        for (int i = 0; i < 5; i++) begin
            apply_settings(gains[i], offsets[i]);
            send_reading({8'hFF, 8'hFE, 8'h80, 8'h7F, 8'h02, 8'h01, 8'h00});
            drain_results();
        end
    endtask

    // random readings under random settings with the given idling
    task automatic test_random_phase(input int send_pct, input int recv_pct, input int n_items);
        logic [15:0] gain;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int s = 0; s < 2; s++) begin
            case ($urandom_range(4))
                0:       gain = 16'h0000;
                1:       gain = 16'h0100;
                2:       gain = 16'hFFFF;
                3:       gain = 16'($urandom_range(1023));
                default: gain = 16'($urandom);
            endcase
            apply_settings(gain, int'($urandom_range(511)) - 256);
            for (int i = 0; i < n_items / 2; i++) send_reading(random_reading());
            drain_results();
        end
    endtask

    initial begin
        for (int b = 0; b < BANDS; b++) begin
            for (int k = 0; k < WINDOW; k++) level_window[b][k] = 8'h00;
        end
        window_slot    = 0;
        gain_setting   = 16'd256;
        offset_setting = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_early_window();
        test_window_wrap();
        test_gain_offset_extremes();
        test_random_phase(0, 0, 50);
        test_random_phase(73, 0, 50);
        test_random_phase(0, 73, 50);
        test_random_phase(32, 32, 50);

        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ band_window_average_and_gain_top.f @@
rtl/bwag_pkg.sv
rtl/bwag_lane.sv
rtl/bwag_merge.sv
rtl/band_window_average_and_gain_top.sv
bench/tb_band_window_average_and_gain_top.sv
